// ===== rtl/scba_pkg.sv =====
`timescale 1ns / 1ps
package scba_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_POOL_OK   = 3'd0,
    ST_HEAP      = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_NOT_POOL  = 3'd3,
    ST_BAD_FREE  = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN_BLOCK = 2'd0,
    REG_LEVEL     = 2'd1,
    REG_MAX_LVL   = 2'd2,
    REG_OVERHEAD  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RMW,
    FSM_OUT,
    FSM_WIPE,
    FSM_SIZE,
    FSM_DIV
  } fsm_e;

  localparam int unsigned CfgW = 24;

endpackage

// ===== rtl/size_class_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// Size-class block allocator with power-of-two classes.
// Input channel (in_valid_i / in_stall_o) carries one item: a command
// (allocate, free, clear) with its request size or block reference.
// Output channel (out_valid_o / out_stall_i) returns one item per command;
// command three is dropped with no result.
// Allocate and free: the class entry and in-use flag are read at the
// accepting edge, the next cycle modifies and writes back, and the result
// is registered at its end (when the block is popped from a freed stack,
// the stack read adds the OUT state before the result). The next item is
// taken the cycle after the result is accepted.
// Clear: a sweep over all LEVELS*MAX_BLOCKS in-use flags, one a cycle, then
// per class a setup state and a restoring divide for the block count; once
// a class does not fit, the remaining classes are cleared without a divide.
// Reset runs the same clear pass (without a result); no item is taken
// until it finishes. Configuration writes are taken at any time.
// When the receiver stalls, the result holds and no new item is accepted.
module size_class_block_allocator_unit
  import scba_pkg::*;
#(
  parameter int unsigned LEVELS     = 8,
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      command_i,
  input  logic [23:0]     request_bytes_i,
  input  logic [3:0]      free_class_i,
  input  logic [7:0]      free_index_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [2:0]      out_class_o,
  output logic [7:0]      out_index_o,
  output logic [8:0]      used_in_class_o
);

  localparam int unsigned CW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW  = CW + BW;
  localparam int unsigned SLOTS = LEVELS * MAX_BLOCKS;
  localparam int unsigned LW  = $clog2(LEVELS + 1);
  localparam int unsigned PW  = 17 + LEVELS;

  typedef struct packed {
    logic [NW-1:0] blocks;
    logic [NW-1:0] depth;
    logic [NW-1:0] fresh;
    logic [NW-1:0] used;
  } cls_t;

  // configuration
  logic [16:0] min_q;
  logic [23:0] lvl_q;
  logic [3:0]  maxl_q;
  logic [7:0]  ovh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= 17'd16;
      lvl_q  <= 24'd65536;
      maxl_q <= 4'd8;
      ovh_q  <= 8'd24;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MIN_BLOCK: min_q  <= cfg_data_i[16:0];
        REG_LEVEL:     lvl_q  <= cfg_data_i[23:0];
        REG_MAX_LVL:   maxl_q <= cfg_data_i[3:0];
        REG_OVERHEAD:  ovh_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // memories: per-class record, in-use flags, freed stacks
  cls_t          cls_mem [LEVELS];
  logic          flag_mem [SLOTS];
  logic [BW-1:0] stk_mem [SLOTS];

  logic          cls_we, flag_we, stk_we;
  logic [CW-1:0] cls_waddr, cls_raddr;
  cls_t          cls_wdata, cls_rd_q;
  logic [SW-1:0] flag_waddr, flag_raddr, stk_waddr, stk_raddr;
  logic          flag_wdata, flag_rd_q;
  logic [BW-1:0] stk_wdata, stk_rd_q;

  always_ff @(posedge clk_i) begin
    if (cls_we) cls_mem[cls_waddr] <= cls_wdata;
    cls_rd_q <= cls_mem[cls_raddr];
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    flag_rd_q <= flag_mem[flag_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  // control registers
  fsm_e          st_q, st_d;
  logic          quiet_q, quiet_d;   // clear after reset: no result
  logic [SW:0]   wcnt_q, wcnt_d;
  logic [CW:0]   lv_q, lv_d;
  logic          stop_q, stop_d;
  logic [LW-1:0] ccnt_q, ccnt_d;
  logic          ov_q, ov_d;
  logic [2:0]    ost_q, ost_d;
  logic [2:0]    ocls_q, ocls_d;
  logic [7:0]    oidx_q, oidx_d;
  logic [8:0]    oused_q, oused_d;
  // held item
  logic [1:0]    cmd_q, cmd_d;
  logic [CW-1:0] ccls_q, ccls_d;
  logic [BW-1:0] cidx_q, cidx_d;
  logic          fit_q, fit_d;
  logic [2:0]    pre_q, pre_d;      // early status (not pool / zero / heap)
  // divider
  logic [PW:0]   dvs_q, dvs_d;
  logic [23:0]   rem_q, rem_d;
  logic [23:0]   quo_q, quo_d;
  logic [4:0]    dcnt_q, dcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FSM_WIPE; quiet_q <= 1'b1; wcnt_q <= '0; lv_q <= '0;
      stop_q <= 1'b0; ccnt_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; quiet_q <= quiet_d; wcnt_q <= wcnt_d; lv_q <= lv_d;
      stop_q <= stop_d; ccnt_q <= ccnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q <= ost_d; ocls_q <= ocls_d; oidx_q <= oidx_d; oused_q <= oused_d;
    cmd_q <= cmd_d; ccls_q <= ccls_d; cidx_q <= cidx_d; fit_q <= fit_d;
    pre_q <= pre_d; dvs_q <= dvs_d; rem_q <= rem_d; quo_q <= quo_d;
    dcnt_q <= dcnt_d;
  end

  // smallest fitting class: payload min<<c >= req, c < class_count
  logic [CW-1:0] fit_cls;
  logic          fit_ok;
  logic [PW-1:0] pay;
  always_comb begin
    fit_cls = '0;
    fit_ok  = 1'b0;
    pay     = '0;
    for (int c = LEVELS - 1; c >= 0; c--) begin
      pay = PW'(min_q) << c;
      if (c < int'(ccnt_q) && pay >= PW'(request_bytes_i)) begin
        fit_cls = CW'(c);
        fit_ok  = 1'b1;
      end
    end
  end

  logic          in_acc;
  logic [PW:0]   blk;
  logic [PW:0]   trial;
  cls_t          rec;
  logic [NW-1:0] idx_n;

  assign in_stall_o  = !(st_q == FSM_IDLE && !ov_q);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign status_o        = ost_q;
  assign out_class_o     = ocls_q;
  assign out_index_o     = oidx_q;
  assign used_in_class_o = oused_q;

  always_comb begin
    st_d = st_q; quiet_d = quiet_q; wcnt_d = wcnt_q; lv_d = lv_q;
    stop_d = stop_q; ccnt_d = ccnt_q;
    ov_d = ov_q && out_stall_i;
    ost_d = ost_q; ocls_d = ocls_q; oidx_d = oidx_q; oused_d = oused_q;
    cmd_d = cmd_q; ccls_d = ccls_q; cidx_d = cidx_q; fit_d = fit_q;
    pre_d = pre_q; dvs_d = dvs_q; rem_d = rem_q; quo_d = quo_q;
    dcnt_d = dcnt_q;
    cls_we = 1'b0; cls_waddr = ccls_q; cls_wdata = cls_rd_q;
    cls_raddr = ccls_q;
    flag_we = 1'b0; flag_waddr = {ccls_q, cidx_q}; flag_wdata = 1'b0;
    flag_raddr = {ccls_q, cidx_q};
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = cidx_q; stk_raddr = '0;
    rec = cls_rd_q; idx_n = '0;
    blk = (PW+1)'(PW'(min_q) << lv_q[CW-1:0]) + (PW+1)'(ovh_q);
    trial = '0;
    case (st_q)
      FSM_IDLE: begin
        // free reads the named class, allocate the fitting one
        cls_raddr = (cmd_e'(command_i) == CMD_FREE) ? free_class_i[CW-1:0] : fit_cls;
        flag_raddr = {free_class_i[CW-1:0], free_index_i[BW-1:0]};
        if (in_acc) begin
          cmd_d = command_i;
          case (cmd_e'(command_i))
            CMD_ALLOC: begin
              ccls_d = fit_cls;
              fit_d = fit_ok;
              pre_d = (request_bytes_i == '0) ? ST_ZERO_SIZE :
                      (!fit_ok ? ST_HEAP : ST_POOL_OK);
              st_d = FSM_RMW;
            end
            CMD_FREE: begin
              ccls_d = free_class_i[CW-1:0];
              cidx_d = free_index_i[BW-1:0];
              pre_d = (32'(free_class_i) >= 32'(ccnt_q) ||
                       32'(free_index_i) >= MAX_BLOCKS) ? ST_NOT_POOL : ST_POOL_OK;
              st_d = FSM_RMW;
            end
            CMD_CLEAR: begin
              quiet_d = 1'b0; wcnt_d = '0; st_d = FSM_WIPE;
            end
            default: ;
          endcase
        end
      end
      FSM_RMW: begin
        // stack top read address for alloc pop
        stk_raddr = {ccls_q, BW'(rec.depth - NW'(1))};
        ost_d = ST_POOL_OK; ocls_d = 3'(ccls_q); oidx_d = '0;
        oused_d = 9'(rec.used);
        if (cmd_e'(cmd_q) == CMD_ALLOC) begin
          if (pre_q != ST_POOL_OK) begin
            ost_d = pre_q; ocls_d = '0; oused_d = '0; ov_d = 1'b1; st_d = FSM_IDLE;
          end else if (rec.depth != '0) begin
            rec.depth = rec.depth - NW'(1);
            rec.used = rec.used + NW'(1);
            cls_we = 1'b1; cls_wdata = rec;
            oused_d = 9'(rec.used);
            st_d = FSM_OUT;
          end else if (rec.fresh < rec.blocks) begin
            idx_n = rec.fresh;
            rec.fresh = rec.fresh + NW'(1);
            rec.used = rec.used + NW'(1);
            cls_we = 1'b1; cls_wdata = rec;
            flag_we = 1'b1; flag_waddr = {ccls_q, BW'(idx_n)}; flag_wdata = 1'b1;
            oidx_d = 8'(idx_n); oused_d = 9'(rec.used);
            ov_d = 1'b1; st_d = FSM_IDLE;
          end else begin
            ost_d = ST_HEAP; ov_d = 1'b1; st_d = FSM_IDLE;
          end
        end else begin
          oidx_d = 8'(cidx_q);
          if (pre_q != ST_POOL_OK || NW'(cidx_q) >= rec.blocks) begin
            ost_d = ST_NOT_POOL; ocls_d = '0; oidx_d = '0; oused_d = '0;
          end else if (!flag_rd_q) begin
            ost_d = ST_BAD_FREE;
          end else begin
            flag_we = 1'b1; flag_wdata = 1'b0;
            if (rec.depth < NW'(MAX_BLOCKS)) begin
              stk_we = 1'b1; stk_waddr = {ccls_q, BW'(rec.depth)};
              rec.depth = rec.depth + NW'(1);
            end
            if (rec.used != '0) rec.used = rec.used - NW'(1);
            cls_we = 1'b1; cls_wdata = rec;
            oused_d = 9'(rec.used);
          end
          ov_d = 1'b1; st_d = FSM_IDLE;
        end
      end
      FSM_OUT: begin
        // popped index arrives from the stack memory
        flag_we = 1'b1; flag_waddr = {ccls_q, stk_rd_q}; flag_wdata = 1'b1;
        ost_d = ST_POOL_OK; ocls_d = 3'(ccls_q); oidx_d = 8'(stk_rd_q);
        ov_d = 1'b1; st_d = FSM_IDLE;
      end
      FSM_WIPE: begin
        flag_we = 1'b1; flag_waddr = wcnt_q[SW-1:0]; flag_wdata = 1'b0;
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == (SW+1)'(SLOTS - 1)) begin
          lv_d = '0; stop_d = 1'b0; ccnt_d = '0; st_d = FSM_SIZE;
        end
      end
      FSM_SIZE: begin
        // per class: decide fit, start divide
        if (!stop_q && lv_q < (CW+1)'(LEVELS) && 32'(lv_q) < 32'(maxl_q) &&
            blk < (PW+1)'(lvl_q)) begin
          dvs_d = blk; rem_d = '0; quo_d = lvl_q; dcnt_d = '0;
          st_d = FSM_DIV;
        end else begin
          stop_d = 1'b1;
          rec = '0;
          cls_we = 1'b1; cls_waddr = lv_q[CW-1:0]; cls_wdata = rec;
          lv_d = lv_q + 1'b1;
          if (lv_q == (CW+1)'(LEVELS - 1)) begin
            st_d = FSM_IDLE;
            if (!quiet_q) begin
              ost_d = ST_CLEARED; ocls_d = '0; oidx_d = '0; oused_d = '0;
              ov_d = 1'b1;
            end
          end
        end
      end
      FSM_DIV: begin
        // restoring divide, one quotient bit a cycle
        trial = {rem_q[22:0], quo_q[23]} - dvs_q;
        quo_d = {quo_q[22:0], ~trial[PW]};
        rem_d = trial[PW] ? {rem_q[22:0], quo_q[23]} : trial[23:0];
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 5'd23) begin
          rec = '0;
          rec.blocks = (quo_d > 24'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(quo_d);
          if (dvs_q == '0) rec.blocks = NW'(MAX_BLOCKS);
          cls_we = 1'b1; cls_waddr = lv_q[CW-1:0]; cls_wdata = rec;
          ccnt_d = LW'(lv_q + 1'b1);
          lv_d = lv_q + 1'b1;
          st_d = FSM_SIZE;
          if (lv_q == (CW+1)'(LEVELS - 1)) begin
            st_d = FSM_IDLE;
            if (!quiet_q) begin
              ost_d = ST_CLEARED; ocls_d = '0; oidx_d = '0; oused_d = '0;
              ov_d = 1'b1;
            end
          end
        end
      end
      default: st_d = FSM_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != FSM_IDLE) |-> in_stall_o) else $error("item taken while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(ost_q) && $stable(oidx_q)))
    else $error("stalled result changed");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == FSM_RMW && ov_q) |-> 1'b0) else $error("result overrun");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == FSM_DIV) |-> (dcnt_q <= 5'd23)) else $error("divide overrun");
`endif

endmodule
